/* rtl/core/decimal_text_to_fp2_parser_unit_defines.svh */
// assertion macros for the decimal text to fp2 parser
`ifndef DECIMAL_TEXT_TO_FP2_PARSER_UNIT_DEFINES_SVH
`define DECIMAL_TEXT_TO_FP2_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define DTFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked also across reset
`define DTFP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTFP_ASSERT(lbl, prop, msg)
`define DTFP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* rtl/core/dtfp_pkg.sv */
package dtfp_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CODE_W    = 16;
  localparam int ACC_W     = 14;

  localparam logic [CFG_IDX_W-1:0] REG_NAN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_INF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEG_INF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL    = 3'd3;

  localparam logic [CODE_W-1:0] NAN_CODE_RST     = 16'h9FFE;
  localparam logic [CODE_W-1:0] POS_INF_CODE_RST = 16'h1FFF;
  localparam logic [CODE_W-1:0] NEG_INF_CODE_RST = 16'h9FFF;
  localparam logic [CODE_W-1:0] FAIL_CODE_RST    = 16'hFFFF;

  localparam logic [ACC_W-1:0] SIG_MAX = 14'd7999;

  // decimal position field
  localparam logic [1:0] POS0 = 2'd0;
  localparam logic [1:0] POS1 = 2'd1;
  localparam logic [1:0] POS2 = 2'd2;
  localparam logic [1:0] POS3 = 2'd3;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_CASE  = 8'h20;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_N     = 8'h6E;

  typedef enum logic [7:0] {
    MATCH_START = 8'b0000_0001,
    MATCH_N     = 8'b0000_0010,
    MATCH_NA    = 8'b0000_0100,
    MATCH_NAN   = 8'b0000_1000,
    MATCH_I     = 8'b0001_0000,
    MATCH_IN    = 8'b0010_0000,
    MATCH_INF   = 8'b0100_0000,
    MATCH_DEAD  = 8'b1000_0000
  } match_t;

  typedef struct packed {
    logic             is_nan;
    logic             is_inf;
    logic             bad;
    logic             neg;
    logic [ACC_W-1:0] sig;
    logic [ACC_W-1:0] ip;
    logic [1:0]       frac;
  } snap_t;

endpackage

/* rtl/core/decimal_text_to_fp2_parser_unit.sv */
// decimal text to fp2 parser
//
// input channel: one ascii character per transfer (char_code), last_char set
// on the final character of a string. in_valid/in_stall handshake.
// output channel: one fp2_word and parse_ok per string, given for the
// transfer that carried last_char. out_valid/out_stall handshake.
// config port: cfg_we writes cfg_data into the code register selected by
// cfg_index (0 nan, 1 inf, 2 -inf, 3 fail); other indexes are ignored.
//
// throughput: one character per cycle while in_stall is low. after the last
// character transfer, the result is registered first in the snapshot
// register and then in the result register.
// when the receiver stalls, the result register holds; the snapshot stage
// still takes one more string end, and after that in_stall holds every
// character until the result register is free again.
// reset clears all string state, empties both stages and loads the default
// special codes.
`include "decimal_text_to_fp2_parser_unit_defines.svh"

module decimal_text_to_fp2_parser_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       char_code,
  input  logic                             last_char,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [15:0]                      fp2_word,
  output logic                             parse_ok,
  input  logic                             cfg_we,
  input  logic [dtfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                      cfg_data
);

  logic [15:0] nan_code;
  logic [15:0] pos_inf_code;
  logic [15:0] neg_inf_code;
  logic [15:0] fail_code;

  logic [2:0]                   char_count, char_count_next;
  logic                         negative_seen, negative_seen_next;
  logic [2:0]                   digit_count, digit_count_next;
  logic [dtfp_pkg::ACC_W-1:0]   significand_acc, significand_acc_next;
  logic [dtfp_pkg::ACC_W-1:0]   integer_part, integer_part_next;
  logic [1:0]                   fraction_digits, fraction_digits_next;
  logic                         point_seen, point_seen_next;
  logic                         syntax_failed, syntax_failed_next;
  dtfp_pkg::match_t             special_match, special_match_next;

  dtfp_pkg::snap_t snap, snap_next;
  logic            snap_valid;
  logic            snap_adv;
  logic            in_acc;

  logic [7:0]  lc;
  logic        first;
  logic        is_digit;

  logic                       over;
  logic [1:0]                 pos;
  logic [dtfp_pkg::ACC_W-1:0] scaled;
  logic [15:0]                word_next;
  logic                       ok_next;

  assign snap_adv = !out_valid || !out_stall;
  assign in_stall = snap_valid && !snap_adv;
  assign in_acc   = in_valid && !in_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      nan_code     <= dtfp_pkg::NAN_CODE_RST;
      pos_inf_code <= dtfp_pkg::POS_INF_CODE_RST;
      neg_inf_code <= dtfp_pkg::NEG_INF_CODE_RST;
      fail_code    <= dtfp_pkg::FAIL_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtfp_pkg::REG_NAN:     nan_code     <= cfg_data;
        dtfp_pkg::REG_POS_INF: pos_inf_code <= cfg_data;
        dtfp_pkg::REG_NEG_INF: neg_inf_code <= cfg_data;
        dtfp_pkg::REG_FAIL:    fail_code    <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-character state update
  always_comb begin
    lc = char_code;
    if (char_code >= dtfp_pkg::CH_UP_A && char_code <= dtfp_pkg::CH_UP_Z) begin
      lc = char_code + dtfp_pkg::CH_CASE;
    end
    first    = (char_count == 3'd0);
    is_digit = (char_code >= dtfp_pkg::CH_0) && (char_code <= dtfp_pkg::CH_9);

    unique case (special_match)
      dtfp_pkg::MATCH_START: begin
        if (first && char_code == dtfp_pkg::CH_MINUS) begin
          special_match_next = dtfp_pkg::MATCH_START;
        end else if (lc == dtfp_pkg::CH_N && !negative_seen) begin
          special_match_next = dtfp_pkg::MATCH_N;
        end else if (lc == dtfp_pkg::CH_I) begin
          special_match_next = dtfp_pkg::MATCH_I;
        end else begin
          special_match_next = dtfp_pkg::MATCH_DEAD;
        end
      end
      dtfp_pkg::MATCH_N:
        special_match_next = (lc == dtfp_pkg::CH_A) ? dtfp_pkg::MATCH_NA : dtfp_pkg::MATCH_DEAD;
      dtfp_pkg::MATCH_NA:
        special_match_next = (lc == dtfp_pkg::CH_N) ? dtfp_pkg::MATCH_NAN : dtfp_pkg::MATCH_DEAD;
      dtfp_pkg::MATCH_I:
        special_match_next = (lc == dtfp_pkg::CH_N) ? dtfp_pkg::MATCH_IN : dtfp_pkg::MATCH_DEAD;
      dtfp_pkg::MATCH_IN:
        special_match_next = (lc == dtfp_pkg::CH_F) ? dtfp_pkg::MATCH_INF : dtfp_pkg::MATCH_DEAD;
      default:
        special_match_next = dtfp_pkg::MATCH_DEAD;
    endcase

    negative_seen_next   = negative_seen;
    digit_count_next     = digit_count;
    significand_acc_next = significand_acc;
    integer_part_next    = integer_part;
    fraction_digits_next = fraction_digits;
    point_seen_next      = point_seen;
    syntax_failed_next   = syntax_failed;

    priority if (first && char_code == dtfp_pkg::CH_MINUS) begin
      negative_seen_next = 1'b1;
    end else if (!last_char && char_code == dtfp_pkg::CH_DOT) begin
      if (digit_count == 3'd0 || point_seen) begin
        syntax_failed_next = 1'b1;
      end else begin
        integer_part_next = significand_acc;
        point_seen_next   = 1'b1;
      end
    end else if (is_digit) begin
      if (digit_count >= 3'd4) begin
        syntax_failed_next = 1'b1;
      end else begin
        // at most three digits held here, so the sum stays below 10000
        significand_acc_next = significand_acc * 14'd10 + {10'd0, char_code[3:0]};
        digit_count_next     = digit_count + 3'd1;
        if (point_seen) begin
          fraction_digits_next = fraction_digits + 2'd1;
        end
      end
    end else begin
      syntax_failed_next = 1'b1;
    end

    char_count_next = (char_count == 3'd7) ? 3'd7 : char_count + 3'd1;

    snap_next.is_nan = (special_match_next == dtfp_pkg::MATCH_NAN);
    snap_next.is_inf = (special_match_next == dtfp_pkg::MATCH_INF);
    snap_next.bad    = syntax_failed_next || (char_count_next == 3'd7) ||
                       (digit_count_next == 3'd0);
    snap_next.neg    = negative_seen_next;
    snap_next.sig    = significand_acc_next;
    snap_next.ip     = point_seen_next ? integer_part_next : significand_acc_next;
    snap_next.frac   = fraction_digits_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count      <= 3'd0;
      negative_seen   <= 1'b0;
      digit_count     <= 3'd0;
      significand_acc <= '0;
      integer_part    <= '0;
      fraction_digits <= 2'd0;
      point_seen      <= 1'b0;
      syntax_failed   <= 1'b0;
      special_match   <= dtfp_pkg::MATCH_START;
    end else if (in_acc) begin
      if (last_char) begin
        // string done, start over
        char_count      <= 3'd0;
        negative_seen   <= 1'b0;
        digit_count     <= 3'd0;
        significand_acc <= '0;
        integer_part    <= '0;
        fraction_digits <= 2'd0;
        point_seen      <= 1'b0;
        syntax_failed   <= 1'b0;
        special_match   <= dtfp_pkg::MATCH_START;
      end else begin
        char_count      <= char_count_next;
        negative_seen   <= negative_seen_next;
        digit_count     <= digit_count_next;
        significand_acc <= significand_acc_next;
        integer_part    <= integer_part_next;
        fraction_digits <= fraction_digits_next;
        point_seen      <= point_seen_next;
        syntax_failed   <= syntax_failed_next;
        special_match   <= special_match_next;
      end
    end
  end

  // snapshot stage
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (in_acc && last_char) begin
      snap_valid <= 1'b1;
    end else if (snap_adv) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && last_char) begin
      snap <= snap_next;
    end
  end

  // conversion of the snapshot
  always_comb begin
    over   = snap.sig > dtfp_pkg::SIG_MAX;
    pos    = dtfp_pkg::POS0;
    scaled = snap.sig;
    priority if (snap.sig == '0) begin
      pos = dtfp_pkg::POS0;
    end else if (snap.ip < 14'd8) begin
      pos = dtfp_pkg::POS3;
      priority if (snap.ip == '0) begin
        // pure fraction: scale by the fraction digits present
        if (snap.frac == 2'd1) begin
          scaled = snap.sig * 14'd100;
        end else if (snap.frac == 2'd2) begin
          scaled = snap.sig * 14'd10;
        end
      end else if (snap.sig < 14'd8) begin
        scaled = snap.sig * 14'd1000;
      end else if (snap.sig < 14'd80) begin
        scaled = snap.sig * 14'd100;
      end else if (snap.sig < 14'd800) begin
        scaled = snap.sig * 14'd10;
      end else begin
        scaled = snap.sig;
      end
    end else if (snap.ip < 14'd80) begin
      pos = dtfp_pkg::POS2;
      if (snap.sig < 14'd80) begin
        scaled = snap.sig * 14'd100;
      end else if (snap.sig < 14'd800) begin
        scaled = snap.sig * 14'd10;
      end
    end else if (snap.ip < 14'd800) begin
      pos = dtfp_pkg::POS1;
      if (snap.sig < 14'd800) begin
        scaled = snap.sig * 14'd10;
      end
    end else begin
      pos = dtfp_pkg::POS0;
    end

    priority if (snap.is_nan) begin
      word_next = nan_code;
      ok_next   = 1'b1;
    end else if (snap.is_inf) begin
      word_next = snap.neg ? neg_inf_code : pos_inf_code;
      ok_next   = 1'b1;
    end else if (snap.bad || over) begin
      word_next = fail_code;
      ok_next   = 1'b0;
    end else begin
      word_next = {snap.neg, pos, scaled[12:0]};
      ok_next   = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_adv) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_adv && snap_valid) begin
      fp2_word <= word_next;
      parse_ok <= ok_next;
    end
  end

  `DTFP_ASSERT(a_fail_word, out_valid && !parse_ok |-> fp2_word == fail_code, "fail flag without fail code")
  `DTFP_ASSERT(a_end_to_snap, in_acc && last_char |=> snap_valid, "string end lost before snapshot")
  `DTFP_ASSERT(a_end_clears, in_acc && last_char |=> char_count == 3'd0 && digit_count == 3'd0 && !point_seen, "string state not cleared")
  `DTFP_ASSERT(a_digit_bound, digit_count <= 3'd4, "digit count above four")
  `DTFP_ASSERT_RST(a_reset_empty, rst |=> !out_valid && !snap_valid, "pipeline not empty after reset")

endmodule
